>>> hw/rtl/oac_pkg.sv
package oac_pkg;

    // Field and register widths
    localparam int ANG_W      = 16;
    localparam int RAD_W      = 16;
    localparam int POS_W      = 17;
    localparam int TRIG_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // CORDIC sizing
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int IDX_W        = $clog2(CORDIC_N);
    localparam int ATAN_IDX_W   = 5;
    localparam int CW           = 34;    // Q2.30 plus guard bits
    localparam int PROD_W       = 34;    // product width for the Q8.8 x Q1.15 multiplies

    localparam logic [IDX_W-1:0]     LAST_IDX    = IDX_W'(CORDIC_N - 1);
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] HALF_Q15    = 34'sd16384;
    localparam logic signed [CW-1:0] SAT_HI      = 34'sd32767;
    localparam logic signed [CW-1:0] SAT_LO      = -34'sd32767;
    localparam logic signed [PROD_W-1:0] HALF_P  = 34'sd16384;

    // Reset values of the configuration registers
    localparam logic [RAD_W-1:0]        RADIUS_RST = 16'd256;
    localparam logic signed [ANG_W-1:0] EL_MAX_RST = 16'sd7282;
    localparam logic signed [ANG_W-1:0] EL_MIN_RST = -16'sd7282;

    // Quarter turn, used to fold angles into [-90, +90] degrees
    localparam logic signed [ANG_W:0] QUARTER = 17'sd16384;
    localparam logic signed [ANG_W:0] HALF    = 17'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_EL_MAX = 2'd1,
        REG_EL_MIN = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ITER,
        ST_ROUND,
        ST_MUL_T,
        ST_MUL_XZ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             load;      // take request, update angles
        logic             init;      // fold angles, seed CORDIC lanes
        logic             step;      // one CORDIC micro-rotation
        logic [IDX_W-1:0] step_idx;
        logic             round;     // round and saturate sin/cos
        logic             mul_t;     // t = r*cos(el), y = r*sin(el)
        logic             mul_xz;    // x = t*cos(az), z = t*sin(az)
        logic             out_load;  // copy results to output register
    } cmd_t;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic signed [CW-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0:    v = 34'sh020000000;
            5'd1:    v = 34'sh012E4051E;
            5'd2:    v = 34'sh009FB385B;
            5'd3:    v = 34'sh0051111D4;
            5'd4:    v = 34'sh0028B0D43;
            5'd5:    v = 34'sh00145D7E1;
            5'd6:    v = 34'sh000A2F61E;
            5'd7:    v = 34'sh000517C55;
            5'd8:    v = 34'sh00028BE53;
            5'd9:    v = 34'sh000145F2F;
            5'd10:   v = 34'sh0000A2F98;
            5'd11:   v = 34'sh0000517CC;
            5'd12:   v = 34'sh000028BE6;
            5'd13:   v = 34'sh0000145F3;
            5'd14:   v = 34'sh000000A2F9;
            5'd15:   v = 34'sh00000517C;
            5'd16:   v = 34'sh0000028BE;
            5'd17:   v = 34'sh00000145F;
            5'd18:   v = 34'sh000000A2F;
            5'd19:   v = 34'sh000000517;
            5'd20:   v = 34'sh00000028B;
            5'd21:   v = 34'sh000000145;
            5'd22:   v = 34'sh0000000A2;
            5'd23:   v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/oac_if.sv
interface oac_req_if;
    import oac_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANG_W-1:0]   delta_azimuth;
    logic signed [ANG_W-1:0]   delta_elevation;

    modport source (output valid, output delta_azimuth, output delta_elevation, input ready);
    modport sink   (input valid, input delta_azimuth, input delta_elevation, output ready);
endinterface

interface oac_res_if;
    import oac_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic [ANG_W-1:0]          azimuth_now;
    logic signed [ANG_W-1:0]   elevation_now;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output azimuth_now, output elevation_now, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input azimuth_now, input elevation_now, output ready);
endinterface

>>> hw/rtl/oac_ctrl.sv
module oac_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output oac_pkg::cmd_t cmd
);
    import oac_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.step_idx   = idx_reg;
        out_valid_next = out_valid_reg;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                idx_next   = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.step = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_MUL_T;
            end
            ST_MUL_T:
            begin
                cmd.mul_t  = 1'b1;
                state_next = ST_MUL_XZ;
            end
            ST_MUL_XZ:
            begin
                cmd.mul_xz = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait until the output register is free or being drained
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/oac_dp.sv
module oac_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  oac_pkg::cmd_t                          cmd,
    input  logic                                   cfg_wr_en,
    input  logic [oac_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [oac_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic signed [oac_pkg::ANG_W-1:0]       delta_azimuth,
    input  logic signed [oac_pkg::ANG_W-1:0]       delta_elevation,
    output logic signed [oac_pkg::POS_W-1:0]       pos_x,
    output logic signed [oac_pkg::POS_W-1:0]       pos_y,
    output logic signed [oac_pkg::POS_W-1:0]       pos_z,
    output logic [oac_pkg::ANG_W-1:0]              azimuth_now,
    output logic signed [oac_pkg::ANG_W-1:0]       elevation_now
);
    import oac_pkg::*;

    // configuration
    logic [RAD_W-1:0]        radius_reg;
    logic signed [ANG_W-1:0] el_max_reg;
    logic signed [ANG_W-1:0] el_min_reg;

    // angle state
    logic [ANG_W-1:0]        az_reg, az_next;
    logic signed [ANG_W-1:0] el_reg, el_next;

    // CORDIC lanes: a = azimuth, e = elevation
    logic signed [CW-1:0] ax_reg, ay_reg, az_z_reg;
    logic signed [CW-1:0] ex_reg, ey_reg, ez_reg;
    logic                 a_flip_reg, e_flip_reg;
    logic signed [CW-1:0] ax_next, ay_next, az_z_next;
    logic signed [CW-1:0] ex_next, ey_next, ez_next;

    logic signed [TRIG_W-1:0] sin_az_reg, cos_az_reg, sin_el_reg, cos_el_reg;
    logic signed [POS_W-1:0]  t_reg, y_reg, x_reg, z_reg;

    logic signed [POS_W-1:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic [ANG_W-1:0]         az_out_reg;
    logic signed [ANG_W-1:0]  el_out_reg;

    logic signed [ANG_W:0]    el_sum;
    logic signed [CW:0]       a_seed, e_seed;
    logic signed [PROD_W-1:0] p_t, p_y, p_x, p_z;
    logic signed [CW-1:0]     atan_v;

    // fold into [-quarter, +quarter]; returns {flip, z seed}
    function automatic logic [CW:0] fold(input logic [ANG_W-1:0] ang);
        logic signed [ANG_W:0] a;
        logic                  flip;
        a    = (ANG_W+1)'(signed'(ang));
        flip = 1'b0;
        if (a > QUARTER)
        begin
            a    = a - HALF;
            flip = 1'b1;
        end
        else if (a < -QUARTER)
        begin
            a    = a + HALF;
            flip = 1'b1;
        end
        return {flip, {(CW-ANG_W-17){a[ANG_W]}}, a, 16'b0};
    endfunction

    function automatic logic signed [TRIG_W-1:0] round_sat(input logic signed [CW-1:0] v,
                                                            input logic flip);
        logic signed [CW-1:0]     s;
        logic signed [TRIG_W-1:0] r;
        s = (v + HALF_Q15) >>> 15;
        if (s > SAT_HI)
        begin
            s = SAT_HI;
        end
        else if (s < SAT_LO)
        begin
            s = SAT_LO;
        end
        r = s[TRIG_W-1:0];
        return flip ? -r : r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            el_max_reg <= EL_MAX_RST;
            el_min_reg <= EL_MIN_RST;
            az_reg     <= '0;
            el_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_RADIUS: radius_reg <= cfg_wdata[RAD_W-1:0];
                    REG_EL_MAX: el_max_reg <= cfg_wdata[ANG_W-1:0];
                    REG_EL_MIN: el_min_reg <= cfg_wdata[ANG_W-1:0];
                    default:    ;
                endcase
            end
            if (cmd.load)
            begin
                az_reg <= az_next;
                el_reg <= el_next;
            end
        end
    end

    // angle update with clamp; min is applied last so it wins
    always_comb
    begin
        az_next = az_reg + delta_azimuth;
        el_sum  = (ANG_W+1)'(el_reg) + (ANG_W+1)'(delta_elevation);
        if (el_sum > (ANG_W+1)'(el_max_reg))
        begin
            el_sum = (ANG_W+1)'(el_max_reg);
        end
        if (el_sum < (ANG_W+1)'(el_min_reg))
        begin
            el_sum = (ANG_W+1)'(el_min_reg);
        end
        el_next = el_sum[ANG_W-1:0];
    end

    // CORDIC micro-rotation on both lanes
    always_comb
    begin
        a_seed = fold(az_reg);
        e_seed = fold(el_reg);
        atan_v = atan_lut(ATAN_IDX_W'(cmd.step_idx));
        if (az_z_reg >= 0)
        begin
            ax_next   = ax_reg - (ay_reg >>> cmd.step_idx);
            ay_next   = ay_reg + (ax_reg >>> cmd.step_idx);
            az_z_next = az_z_reg - atan_v;
        end
        else
        begin
            ax_next   = ax_reg + (ay_reg >>> cmd.step_idx);
            ay_next   = ay_reg - (ax_reg >>> cmd.step_idx);
            az_z_next = az_z_reg + atan_v;
        end
        if (ez_reg >= 0)
        begin
            ex_next = ex_reg - (ey_reg >>> cmd.step_idx);
            ey_next = ey_reg + (ex_reg >>> cmd.step_idx);
            ez_next = ez_reg - atan_v;
        end
        else
        begin
            ex_next = ex_reg + (ey_reg >>> cmd.step_idx);
            ey_next = ey_reg - (ex_reg >>> cmd.step_idx);
            ez_next = ez_reg + atan_v;
        end
    end

    always_comb
    begin
        p_t = $signed({1'b0, radius_reg}) * cos_el_reg;
        p_y = $signed({1'b0, radius_reg}) * sin_el_reg;
        p_x = t_reg * cos_az_reg;
        p_z = t_reg * sin_az_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            ax_reg     <= CORDIC_GAIN;
            ay_reg     <= '0;
            az_z_reg   <= a_seed[CW-1:0];
            a_flip_reg <= a_seed[CW];
            ex_reg     <= CORDIC_GAIN;
            ey_reg     <= '0;
            ez_reg     <= e_seed[CW-1:0];
            e_flip_reg <= e_seed[CW];
        end
        else if (cmd.step)
        begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            az_z_reg <= az_z_next;
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
            ez_reg   <= ez_next;
        end
        if (cmd.round)
        begin
            cos_az_reg <= round_sat(ax_reg, a_flip_reg);
            sin_az_reg <= round_sat(ay_reg, a_flip_reg);
            cos_el_reg <= round_sat(ex_reg, e_flip_reg);
            sin_el_reg <= round_sat(ey_reg, e_flip_reg);
        end
        if (cmd.mul_t)
        begin
            t_reg <= POS_W'((p_t + HALF_P) >>> 15);
            y_reg <= POS_W'((p_y + HALF_P) >>> 15);
        end
        if (cmd.mul_xz)
        begin
            x_reg <= POS_W'((p_x + HALF_P) >>> 15);
            z_reg <= POS_W'((p_z + HALF_P) >>> 15);
        end
        if (cmd.out_load)
        begin
            pos_x_reg  <= x_reg;
            pos_y_reg  <= y_reg;
            pos_z_reg  <= z_reg;
            az_out_reg <= az_reg;
            el_out_reg <= el_reg;
        end
    end

    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pos_z         = pos_z_reg;
    assign azimuth_now   = az_out_reg;
    assign elevation_now = el_out_reg;

endmodule

>>> hw/rtl/orbit_angle_to_cartesian.sv
// Channel   Dir  Payload                                              Handshake
// req       in   delta_azimuth, delta_elevation                       valid/ready
// res       out  pos_x, pos_y, pos_z, azimuth_now, elevation_now      valid/ready
// cfg       in   cfg_index, cfg_wdata                                 cfg_wr_en (no stall)
//
// One request at a time: a new request is accepted only in the idle state, which
// the sequencer reaches again once the result is loaded into the output register.
// The CORDIC has one lane per angle; both lanes do one micro-rotation per cycle.
// Reset clears the angles and loads the clamp/radius defaults; no clearing pass.
// The result sits in an output register, so a stalled res does not block the
// next request from being accepted and computed.
module orbit_angle_to_cartesian (
    input  logic                           clk,
    input  logic                           rst_n,
    oac_req_if.sink                        req,
    oac_res_if.source                      res,
    input  logic                           cfg_wr_en,
    input  logic [oac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [oac_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import oac_pkg::*;

    cmd_t cmd;

    // sequencer: request accept, CORDIC iteration count, multiply steps,
    // and the output register valid bit
    oac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd)
    );

    // angle accumulators, clamp, dual-lane CORDIC, radius multiplies
    oac_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .delta_azimuth   (req.delta_azimuth),
        .delta_elevation (req.delta_elevation),
        .pos_x           (res.pos_x),
        .pos_y           (res.pos_y),
        .pos_z           (res.pos_z),
        .azimuth_now     (res.azimuth_now),
        .elevation_now   (res.elevation_now)
    );

endmodule

>>> tb/sv/tb_orbit_angle_to_cartesian.sv
module tb_orbit_angle_to_cartesian;
    import oac_pkg::*;

    // Watchdog: ~500 requests, each worst case its compute time plus the longest
    // source gap plus the longest sink stall, taken several times over.
    localparam int LIMIT_CYCLES  = 400000;
    localparam int TAIL_CYCLES   = 30;     // settle time after the last result
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 60;

    // Rotation count of the angle unit, capped by the arctangent table length
    localparam int ARC_ENTRIES = 24;
    localparam int ROTATIONS   = (CORDIC_STEPS > ARC_ENTRIES) ? ARC_ENTRIES : CORDIC_STEPS;
    localparam longint GAIN_Q30 = 64'sd652032874;   // 1/K in Q2.30

    // Index with no register behind it; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    // atan(2^-i) in 2^32 units per turn
    longint arc_turn [0:ARC_ENTRIES-1] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
        64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    typedef struct {
        logic signed [ANG_W-1:0] d_az;
        logic signed [ANG_W-1:0] d_el;
    } angle_step_t;

    typedef struct {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [ANG_W-1:0]        az;
        logic signed [ANG_W-1:0] el;
    } camera_point_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    oac_req_if req();
    oac_res_if res();

    orbit_angle_to_cartesian dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .res       (res.source),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the block: registers and accumulated camera angles
    logic [RAD_W-1:0]        orbit_radius;
    logic signed [ANG_W-1:0] clamp_max;
    logic signed [ANG_W-1:0] clamp_min;
    logic [ANG_W-1:0]        cam_az = '0;
    logic signed [ANG_W-1:0] cam_el = '0;

    angle_step_t   step_q  [$];   // requests waiting to be driven
    camera_point_t point_q [$];   // predicted camera points, oldest first

    bit calm;                     // no source gaps, no sink stalls
    int gap_left;
    int stall_left;
    int error_count    = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int setting_count;
    int cycle_count;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round half up from Q2.30 (or Q.15 products) down by 15 bits; >>> on a
    // signed longint floors, matching the hardware shifter.
    function automatic longint q15_round(input longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic longint q15_sat(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32767)
            return -32767;
        return v;
    endfunction

    // Rotation-mode CORDIC on a binary angle. Angles past a quarter turn are
    // folded by half a turn, which negates both outputs.
    function automatic void unit_sin_cos(input logic [ANG_W-1:0] ang,
                                         output longint s, output longint c);
        longint a, x, y, z, dx, dy;
        bit flip;
        int i;
        a = longint'($signed(ang));
        flip = 1'b0;
        if (a > 16384)
        begin
            a -= 32768;
            flip = 1'b1;
        end
        else if (a < -16384)
        begin
            a += 32768;
            flip = 1'b1;
        end
        x = GAIN_Q30;
        y = 0;
        z = a * 65536;
        for (i = 0; i < ROTATIONS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arc_turn[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arc_turn[i];
            end
        end
        c = q15_sat(q15_round(x));
        s = q15_sat(q15_round(y));
        if (flip)
        begin
            c = -c;
            s = -s;
        end
    endfunction

    // Apply one angle step to the shadow state and return the camera point
    function automatic camera_point_t advance_camera(input logic signed [ANG_W-1:0] d_az,
                                                     input logic signed [ANG_W-1:0] d_el);
        longint el_sum, saz, caz, sel, cel, r, t;
        camera_point_t p;
        el_sum = longint'(cam_el) + longint'(d_el);
        cam_az = cam_az + d_az;
        // max first, then min: min wins when the two cross
        if (el_sum > longint'(clamp_max))
            el_sum = longint'(clamp_max);
        if (el_sum < longint'(clamp_min))
            el_sum = longint'(clamp_min);
        cam_el = el_sum[ANG_W-1:0];
        unit_sin_cos(cam_az, saz, caz);
        unit_sin_cos(cam_el, sel, cel);
        r = longint'(orbit_radius);
        t = q15_round(r * cel);
        p.pos_x = POS_W'(q15_round(t * caz));
        p.pos_y = POS_W'(q15_round(r * sel));
        p.pos_z = POS_W'(q15_round(t * saz));
        p.az    = cam_az;
        p.el    = cam_el;
        return p;
    endfunction

    // Mostly short idle runs, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: watchdog expired, %0d results still expected", $time, point_q.size());
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: predicts at the accepting edge, then refills the slot
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid           <= 1'b0;
            req.delta_azimuth   <= '0;
            req.delta_elevation <= '0;
            gap_left            <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                point_q.push_back(advance_camera(req.delta_azimuth, req.delta_elevation));
                accepted_count++;
            end
            // slot is free when nothing is offered or the offer was just taken
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    req.valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end
                else if (step_q.size() != 0)
                begin
                    angle_step_t s;
                    s = step_q.pop_front();
                    req.valid           <= 1'b1;
                    req.delta_azimuth   <= s.d_az;
                    req.delta_elevation <= s.d_el;
                    gap_left            <= pick_gap();
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, compares against oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                checked_count++;
                if (point_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d az=%0d el=%0d",
                             $time, res.pos_x, res.pos_y, res.pos_z,
                             res.azimuth_now, res.elevation_now);
                end
                else
                begin
                    camera_point_t want;
                    want = point_q.pop_front();
                    check_field("pos_x", want.pos_x, res.pos_x);
                    check_field("pos_y", want.pos_y, res.pos_y);
                    check_field("pos_z", want.pos_z, res.pos_z);
                    check_field("azimuth_now", want.az, res.azimuth_now);
                    check_field("elevation_now", want.el, res.elevation_now);
                end
            end
            if (stall_left > 0)
            begin
                res.ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                res.ready  <= 1'b0;
                stall_left <= pick_gap();
            end
            else
            begin
                res.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------

    // Register write; only called with the block idle, so the shadow can
    // take the new value right away.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_RADIUS: orbit_radius = value[RAD_W-1:0];
            REG_EL_MAX: clamp_max    = value[ANG_W-1:0];
            REG_EL_MIN: clamp_min    = value[ANG_W-1:0];
            default:    ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_camera(input int rad, input int el_hi, input int el_lo);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_EL_MAX, el_hi);
        write_reg(REG_EL_MIN, el_lo);
        setting_count++;
    endtask

    function automatic void queue_step(input int d_az, input int d_el);
        angle_step_t s;
        s.d_az = d_az[ANG_W-1:0];
        s.d_el = d_el[ANG_W-1:0];
        step_q.push_back(s);
    endfunction

    // Block is idle once nothing is queued, offered or owed
    task automatic wait_idle();
        @(negedge clk);
        while (step_q.size() != 0 || req.valid || point_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int hi, lo, swap, rad, roll, az, el;
        // known values on the configuration port from time zero
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        orbit_radius   = RADIUS_RST;
        clamp_max      = EL_MAX_RST;
        clamp_min      = EL_MIN_RST;
        calm           = 1'b0;
        setting_count  = 1;
        @(posedge rst_n);
        @(negedge clk);

        // Reset defaults (+-40 degrees, radius 1.0); a write to the unused
        // index must leave them alone.
        write_reg(REG_NONE, 16'h1234);
        queue_step(0, 0);
        queue_step(16384, 0);        // azimuth exactly a quarter turn
        queue_step(1, 0);            // just past it: fold
        queue_step(-32768, 0);       // most negative step
        queue_step(-2, 0);           // just below minus a quarter turn
        queue_step(32767, 16384);    // elevation hits the upper clamp
        queue_step(0, -16384);       // and the lower one
        queue_step(-1, -1);
        wait_idle();

        // Full radius, clamps at +-90 degrees
        set_camera(65535, 16384, -16384);
        queue_step(0, 16384);
        queue_step(0, 16384);
        queue_step(16384, -16384);
        queue_step(0, -16384);
        queue_step(0, -16384);
        wait_idle();

        // Zero radius
        set_camera(0, 16384, -16384);
        queue_step(12345, 5000);
        queue_step(-12345, -5000);
        wait_idle();

        // Lower clamp above upper clamp: elevation pinned to the lower one
        set_camera(1000, -1000, 2000);
        queue_step(0, 0);
        queue_step(100, -16384);
        queue_step(100, 16384);
        wait_idle();

        // Clamps past a quarter turn, full 16-bit span: cos(el) goes negative
        set_camera(40000, 32767, -32768);
        queue_step(0, 16384);
        queue_step(0, 16384);
        queue_step(0, -16384);
        queue_step(0, -16384);
        queue_step(0, -16384);
        queue_step(0, -16384);
        wait_idle();

        // Random phases, each with its own radius and clamp pair
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                rad = 0;
            else if (roll == 1)
                rad = 65535;
            else
                rad = $urandom_range(0, 65535);
            hi = int'($urandom_range(0, 32768)) - 16384;
            lo = int'($urandom_range(0, 32768)) - 16384;
            // usually an ordered pair, sometimes crossed
            if (lo > hi && $urandom_range(0, 4) != 0)
            begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            set_camera(rad, hi, lo);
            calm = (phase == 0) || ($urandom_range(0, 4) == 0);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 7)
                    az = $urandom_range(0, 65535);
                else
                    az = int'($urandom_range(0, 1024)) - 512;
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    el = int'($urandom_range(0, 3000)) - 1500;
                else if (roll < 85)
                    el = int'($urandom_range(0, 32768)) - 16384;
                else if (roll < 92)
                    el = 16384;
                else if (roll < 97)
                    el = -16384;
                else
                    el = 0;
                queue_step(az, el);
            end
            wait_idle();
            calm = 1'b0;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d requests and %0d checked results over %0d camera settings,",
                 accepted_count, checked_count, setting_count);
        $display("including crossed clamps, clamps past a quarter turn and radius extremes.");
        if (error_count == 0 && point_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
